>>> src/ttnsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttnsg_pkg: shared types and constants of the tone and noise generator
// Holds the port payload structs, the decoded command that travels from the
// front end to the back end, and the status groups between the parts.
// ----------------------------------------------------------------------------
package ttnsg_pkg;

    // Input opcodes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Channel number of the noise channel; tone channels are 0 to 2.
    localparam logic [1:0] NOISE_CHAN = 2'd3;

    // Noise rate codes with fixed reload values; the remaining code makes
    // the noise counter follow the tone 2 period.
    localparam logic [1:0] RATE_FAST = 2'd0;
    localparam logic [1:0] RATE_MID  = 2'd1;
    localparam logic [1:0] RATE_SLOW = 2'd2;

    // Default depth of the queue between front and back end.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One input item.
    typedef struct packed {
        logic       opcode;
        logic [7:0] write_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [3:0] tone0_level;
        logic [3:0] tone1_level;
        logic [3:0] tone2_level;
        logic [3:0] noise_level;
    } levels_t;

    // Kinds of decoded command.
    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_VOLUME,
        CMD_PERIOD_LO,
        CMD_PERIOD_HI,
        CMD_NOISE_CTRL
    } cmd_kind_t;

    // Decoded command: channel and right-aligned data bits.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [1:0] chan;
        logic [5:0] data;
    } cmd_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // Back end status: a queue pop and whether it was a tick.
    typedef struct packed {
        logic pop;
        logic pop_tick;
    } back_status_t;

endpackage
`default_nettype wire

>>> src/ttnsg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttnsg_front: input front end
// Accepts items, tracks the latched register number and turns every item
// into one decoded command for the queue.
// ----------------------------------------------------------------------------
module ttnsg_front (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       item_valid,
    output logic                      item_stall,
    input  ttnsg_pkg::item_t          item,
    input  ttnsg_pkg::queue_status_t  q_status,
    output logic                      push,
    output ttnsg_pkg::cmd_t           push_cmd
);
    import ttnsg_pkg::*;

    logic [2:0] latched_reg;
    logic [2:0] latched_next;
    logic       latch;
    logic [2:0] reg_num;
    logic       accept;

    // The front end holds off only while the queue is full.
    assign item_stall = q_status.full;
    assign accept     = item_valid && !item_stall;
    assign push       = accept;

    // A byte with bit 7 set names the register it and later bytes address.
    assign latch   = item.write_byte[7];
    assign reg_num = latch ? item.write_byte[6:4] : latched_reg;

    always_comb
    begin
        latched_next = latched_reg;
        if (accept && item.opcode == OP_WRITE && latch)
        begin
            latched_next = item.write_byte[6:4];
        end
    end

    // Classify the item into a command.
    always_comb
    begin
        push_cmd.chan = reg_num[2:1];
        push_cmd.data = {2'b00, item.write_byte[3:0]};
        if (item.opcode == OP_TICK)
        begin
            push_cmd.kind = CMD_TICK;
        end
        else if (reg_num[0])
        begin
            push_cmd.kind = CMD_VOLUME;
        end
        else if (latch)
        begin
            if (reg_num[2:1] == NOISE_CHAN)
            begin
                push_cmd.kind = CMD_NOISE_CTRL;
                push_cmd.data = {3'b000, item.write_byte[2:0]};
            end
            else
            begin
                push_cmd.kind = CMD_PERIOD_LO;
            end
        end
        else if (reg_num[2:1] == NOISE_CHAN)
        begin
            // A data byte on the noise control register sets the noise volume.
            push_cmd.kind = CMD_VOLUME;
        end
        else
        begin
            push_cmd.kind = CMD_PERIOD_HI;
            push_cmd.data = item.write_byte[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= 3'd0;
        end
        else
        begin
            latched_reg <= latched_next;
        end
    end

endmodule
`default_nettype wire

>>> src/ttnsg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttnsg_queue: command queue
// A short first-in first-out queue of decoded commands that decouples the
// front end from the back end.
// ----------------------------------------------------------------------------
module ttnsg_queue #(
    parameter int DEPTH = ttnsg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       push,
    input  ttnsg_pkg::cmd_t           push_cmd,
    input  ttnsg_pkg::back_status_t   back_status,
    output ttnsg_pkg::cmd_t           head,
    output ttnsg_pkg::queue_status_t  q_status
);
    import ttnsg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop            = back_status.pop;
    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> src/ttnsg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttnsg_back: sound generator back end
// Carries out decoded commands: register writes update the channel state,
// ticks step the tone and noise counters and load the result register.
// ----------------------------------------------------------------------------
module ttnsg_back (
    input  wire                       clk,
    input  wire                       rst_n,
    input  ttnsg_pkg::cmd_t           head,
    input  ttnsg_pkg::queue_status_t  q_status,
    output ttnsg_pkg::back_status_t   back_status,
    output logic                      level_valid,
    input  wire                       level_stall,
    output ttnsg_pkg::levels_t        levels
);
    import ttnsg_pkg::*;

    localparam int          NUM_TONES  = 3;
    localparam logic [15:0] LFSR_SEED  = 16'h8000;
    localparam logic [9:0]  RELOAD_R0  = 10'h010;
    localparam logic [9:0]  RELOAD_R1  = 10'h020;
    localparam logic [9:0]  RELOAD_R2  = 10'h040;
    localparam logic [3:0]  LEVEL_MUTE = 4'd15;

    logic [9:0]  tone_cnt_reg    [NUM_TONES];
    logic [9:0]  tone_cnt_next   [NUM_TONES];
    logic [9:0]  tone_per_reg    [NUM_TONES];
    logic [9:0]  tone_per_next   [NUM_TONES];
    logic [NUM_TONES-1:0] tone_phase_reg;
    logic [NUM_TONES-1:0] tone_phase_next;
    logic [3:0]  volume_reg      [4];
    logic [3:0]  volume_next     [4];
    logic [9:0]  noise_cnt_reg;
    logic [9:0]  noise_cnt_next;
    logic [9:0]  noise_per_reg;
    logic [9:0]  noise_per_next;
    logic [1:0]  noise_rate_reg;
    logic [1:0]  noise_rate_next;
    logic        noise_fb_reg;
    logic        noise_fb_next;
    logic [15:0] lfsr_reg;
    logic [15:0] lfsr_next;
    logic        noise_half_reg;
    logic        noise_half_next;
    logic        noise_phase_reg;
    logic        noise_phase_next;
    logic        level_valid_reg;
    logic        level_valid_next;
    levels_t     levels_reg;
    levels_t     levels_next;
    logic        is_tick;
    logic        out_free;
    logic        pop;
    logic        tap;
    logic [9:0]  noise_reload;

    // Writes always drain; a tick waits for a free result register.
    assign is_tick  = (head.kind == CMD_TICK);
    assign out_free = !level_valid_reg || !level_stall;
    assign pop      = !q_status.empty && (!is_tick || out_free);

    assign back_status.pop      = pop;
    assign back_status.pop_tick = pop && is_tick;
    assign level_valid          = level_valid_reg;
    assign levels               = levels_reg;

    // Noise reload value by rate select.
    always_comb
    begin
        case (noise_rate_reg)
            RATE_FAST: noise_reload = RELOAD_R0;
            RATE_MID:  noise_reload = RELOAD_R1;
            RATE_SLOW: noise_reload = RELOAD_R2;
            default:   noise_reload = noise_per_reg;
        endcase
    end

    assign tap = lfsr_reg[0] ^ (lfsr_reg[3] & noise_fb_reg);

    // Register writes and tick stepping.
    always_comb
    begin
        tone_cnt_next    = tone_cnt_reg;
        tone_per_next    = tone_per_reg;
        tone_phase_next  = tone_phase_reg;
        volume_next      = volume_reg;
        noise_cnt_next   = noise_cnt_reg;
        noise_per_next   = noise_per_reg;
        noise_rate_next  = noise_rate_reg;
        noise_fb_next    = noise_fb_reg;
        lfsr_next        = lfsr_reg;
        noise_half_next  = noise_half_reg;
        noise_phase_next = noise_phase_reg;

        if (pop)
        begin
            case (head.kind)
                CMD_TICK:
                begin
                    for (int i = 0; i < NUM_TONES; i++)
                    begin
                        if (tone_cnt_reg[i] == '0)
                        begin
                            tone_cnt_next[i]   = tone_per_reg[i];
                            tone_phase_next[i] = !tone_phase_reg[i];
                        end
                        else
                        begin
                            tone_cnt_next[i] = tone_cnt_reg[i] - 1'b1;
                        end
                    end
                    if (noise_cnt_reg == '0)
                    begin
                        noise_cnt_next  = noise_reload;
                        noise_half_next = !noise_half_reg;
                        // The shift register moves on every second expiry.
                        if (!noise_half_reg)
                        begin
                            noise_phase_next = !lfsr_reg[0];
                            lfsr_next        = {tap, lfsr_reg[15:1]};
                        end
                    end
                    else
                    begin
                        noise_cnt_next = noise_cnt_reg - 1'b1;
                    end
                end
                CMD_VOLUME:
                begin
                    volume_next[head.chan] = head.data[3:0];
                end
                CMD_PERIOD_LO, CMD_PERIOD_HI:
                begin
                    for (int i = 0; i < NUM_TONES; i++)
                    begin
                        if (head.chan == 2'(i))
                        begin
                            if (head.kind == CMD_PERIOD_LO)
                            begin
                                tone_per_next[i] = {tone_per_reg[i][9:4], head.data[3:0]};
                            end
                            else
                            begin
                                tone_per_next[i] = {head.data, tone_per_reg[i][3:0]};
                            end
                        end
                    end
                    // The noise channel follows the tone 2 period.
                    if (head.chan == 2'd2)
                    begin
                        noise_per_next = tone_per_next[2];
                    end
                end
                CMD_NOISE_CTRL:
                begin
                    noise_rate_next = head.data[1:0];
                    noise_fb_next   = head.data[2];
                    lfsr_next       = LFSR_SEED;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register: loaded on a tick, cleared once transferred.
    always_comb
    begin
        level_valid_next = level_valid_reg;
        levels_next      = levels_reg;
        if (pop && is_tick)
        begin
            level_valid_next        = 1'b1;
            levels_next.tone0_level = tone_phase_next[0] ? volume_reg[0] : LEVEL_MUTE;
            levels_next.tone1_level = tone_phase_next[1] ? volume_reg[1] : LEVEL_MUTE;
            levels_next.tone2_level = tone_phase_next[2] ? volume_reg[2] : LEVEL_MUTE;
            levels_next.noise_level = noise_phase_next ? volume_reg[3] : LEVEL_MUTE;
        end
        else if (!level_stall)
        begin
            level_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TONES; i++)
            begin
                tone_cnt_reg[i] <= '0;
                tone_per_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                volume_reg[i] <= '0;
            end
            tone_phase_reg  <= '0;
            noise_cnt_reg   <= '0;
            noise_per_reg   <= '0;
            noise_rate_reg  <= '0;
            noise_fb_reg    <= 1'b0;
            lfsr_reg        <= '0;
            noise_half_reg  <= 1'b0;
            noise_phase_reg <= 1'b0;
            level_valid_reg <= 1'b0;
        end
        else
        begin
            tone_cnt_reg    <= tone_cnt_next;
            tone_per_reg    <= tone_per_next;
            tone_phase_reg  <= tone_phase_next;
            volume_reg      <= volume_next;
            noise_cnt_reg   <= noise_cnt_next;
            noise_per_reg   <= noise_per_next;
            noise_rate_reg  <= noise_rate_next;
            noise_fb_reg    <= noise_fb_next;
            lfsr_reg        <= lfsr_next;
            noise_half_reg  <= noise_half_next;
            noise_phase_reg <= noise_phase_next;
            level_valid_reg <= level_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        levels_reg <= levels_next;
    end

endmodule
`default_nettype wire

>>> src/three_tone_noise_sound_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_tone_noise_sound_generator_top: three-tone plus noise sound generator
// Items on the item channel are register write bytes or sound clock ticks.
// Every tick yields one transfer on the level channel with four attenuations;
// a write yields none.
//
// Both channels move a transfer at a clock edge where valid is high and stall
// is low. The block takes one item per cycle while the queue is not full. An
// accepted tick enters the queue and loads the result register once it is at
// the head and that register is free. The front end decodes items into a
// queue of QUEUE_DEPTH commands; the back end executes one command per cycle
// while no tick at the head waits. When the level receiver stalls, the result
// register holds its value; writes behind it still drain, a tick waits, and
// item_stall rises once the queue is full. Reset clears all channel state,
// the shift register, the queue and the valid flag; no result is valid after reset.
// ----------------------------------------------------------------------------
module three_tone_noise_sound_generator_top #(
    parameter int QUEUE_DEPTH = ttnsg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  ttnsg_pkg::item_t     item,
    output logic                 level_valid,
    input  wire                  level_stall,
    output ttnsg_pkg::levels_t   levels
);
    import ttnsg_pkg::*;

    queue_status_t q_status;
    back_status_t  back_status;
    logic          push;
    cmd_t          push_cmd;
    cmd_t          head;

    ttnsg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    ttnsg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_cmd    (push_cmd),
        .back_status (back_status),
        .head        (head),
        .q_status    (q_status)
    );

    ttnsg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .back_status (back_status),
        .level_valid (level_valid),
        .level_stall (level_stall),
        .levels      (levels)
    );

    // A tick never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pop_tick |-> !(level_valid && level_stall))
        else $error("tick executed while result register was stalled");

    // A new result only appears after a tick was executed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(level_valid) |-> $past(back_status.pop_tick))
        else $error("result appeared without a tick");

    // The back end only pops a non-empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
